@@ rtl/fpl_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the flash page loader.
`default_nettype none

package fpl_pkg;

  // Page geometry: the page size must be a power of two.
  localparam int PAGE_BYTES = 32;
  localparam int PAGE_AW    = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;

  // Register reset values.
  localparam logic [ADDR_W-1:0] APP_START_RESET = 16'h1f00;
  localparam logic [ADDR_W-1:0] LOWEST_RESET    = 16'h1f00;

  // Configuration register indexes.
  localparam logic CFG_APP_START = 1'b0;
  localparam logic CFG_LOWEST    = 1'b1;

  // Command modes of an input transaction.
  localparam logic [2:0] MODE_QUERY_STAGE = 3'd0;
  localparam logic [2:0] MODE_START       = 3'd1;
  localparam logic [2:0] MODE_QUERY_ADDR  = 3'd2;
  localparam logic [2:0] MODE_PUSH        = 3'd3;
  localparam logic [2:0] MODE_COMMIT      = 3'd4;

  // Reply status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ALREADY     = 3'd1;
  localparam logic [2:0] ST_NOT_STARTED = 3'd2;
  localparam logic [2:0] ST_EMPTY       = 3'd3;
  localparam logic [2:0] ST_FAULT       = 3'd4;
  localparam logic [2:0] ST_MISMATCH    = 3'd5;
  localparam logic [2:0] ST_NO_COMMIT   = 3'd6;

  // Result kinds.
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       start;
    logic       set_rejected;
    logic       clear_rejected;
    logic       store;
    logic       clear_loading;
    logic       flush_start;
    logic       flush_full;
    logic       flush_next;
    logic       emit_reply;
    logic       emit_byte;
    logic [2:0] reply_status;
    logic       reply_stop;
    logic       byte_last;
  } fpl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic loading;
    logic rejected;
    logic below;
    logic match;
    logic page_end;
    logic fill_zero;
    logic flush_done;
    logic out_free;
  } fpl_sts_t;

endpackage

`default_nettype wire

@@ rtl/flash_page_loader_top.sv @@
// Flash page loader: a command decoder that loads code into flash one page at a time.
// Each input transaction is one command (query stage, start, query next address, commit) or one
// byte of a push. Push bytes collect in a 32-byte page buffer; when a byte completes a page, the
// page is sent out as 32 byte-write transactions, and commit sends out a partial page the same
// way before its reply. A command or push byte without page writes passes through capture,
// decode and, when it has one, reply; each flushed byte is read from the page buffer by a
// registered read and then loaded into the result register, and a page-completing byte that
// also ends its push is followed by its reply. Input is stalled while a transaction is in
// work; output back pressure holds the flush and the reply.
// The page buffer holds no reset value: a commit or flush must only
// cover bytes that have been pushed since reset.
`default_nettype none

module flash_page_loader_top
  import fpl_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [ADDR_W-1:0]  cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_mode,
  input  wire  [ADDR_W-1:0]  in_claimed_address,
  input  wire  [BYTE_W-1:0]  in_data_byte,
  input  wire                in_first_of_push,
  input  wire                in_last_of_push,
  input  wire                in_has_byte,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_kind,
  output logic [2:0]         out_status,
  output logic               out_stage,
  output logic [ADDR_W-1:0]  out_address_out,
  output logic [BYTE_W-1:0]  out_write_byte,
  output logic               out_stop_app,
  output logic               out_last
);

  fpl_cmd_t cmd;
  fpl_sts_t sts;

  // Command decoder and flush sequencer.
  fpl_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_first_of_push (in_first_of_push),
    .in_last_of_push  (in_last_of_push),
    .in_has_byte      (in_has_byte),
    .sts              (sts),
    .cmd              (cmd)
  );

  // Address, buffer and result registers.
  fpl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_claimed_address (in_claimed_address),
    .in_data_byte       (in_data_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_status         (out_status),
    .out_stage          (out_stage),
    .out_address_out    (out_address_out),
    .out_write_byte     (out_write_byte),
    .out_stop_app       (out_stop_app),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/fpl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/fpl_ctrl.sv @@
// Controller state machine of the flash page loader: decodes commands and sequences flushes.
`default_nettype none

module fpl_ctrl
  import fpl_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [2:0] in_mode,
  input  wire        in_first_of_push,
  input  wire        in_last_of_push,
  input  wire        in_has_byte,
  input  fpl_sts_t   sts,
  output fpl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FLUSH_RD,
    S_FLUSH_WR,
    S_REPLY
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic       first_r, first_nxt;
  logic       lastp_r, lastp_nxt;
  logic       has_r, has_nxt;
  logic [2:0] status_r, status_nxt;
  logic       stop_r, stop_nxt;
  logic       flush_final_r, flush_final_nxt;
  logic       reply_after_r, reply_after_nxt;
  logic [2:0] push_status;

  // Checks on the first item of a push, in priority order.
  always_comb begin
    if (!sts.loading) begin
      push_status = ST_NOT_STARTED;
    end else if (!has_r) begin
      push_status = ST_EMPTY;
    end else if (sts.below) begin
      push_status = ST_FAULT;
    end else if (!sts.match) begin
      push_status = ST_MISMATCH;
    end else begin
      push_status = ST_OK;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    first_nxt       = first_r;
    lastp_nxt       = lastp_r;
    has_nxt         = has_r;
    status_nxt      = status_r;
    stop_nxt        = stop_r;
    flush_final_nxt = flush_final_r;
    reply_after_nxt = reply_after_r;
    cmd             = '0;
    cmd.reply_status = status_r;
    cmd.reply_stop   = stop_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          mode_nxt    = in_mode;
          first_nxt   = in_first_of_push;
          lastp_nxt   = in_last_of_push;
          has_nxt     = in_has_byte;
          state_nxt   = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_nxt = ST_OK;
        stop_nxt   = 1'b0;
        case (mode_r)
          MODE_QUERY_STAGE, MODE_QUERY_ADDR: begin
            state_nxt = S_REPLY;
          end
          MODE_START: begin
            if (sts.loading) begin
              status_nxt = ST_ALREADY;
            end else begin
              cmd.start = 1'b1;
              stop_nxt  = 1'b1;
            end
            state_nxt = S_REPLY;
          end
          MODE_PUSH: begin
            if (first_r && push_status != ST_OK) begin
              // Refused push: answer now and ignore the rest of it.
              cmd.set_rejected = 1'b1;
              status_nxt       = push_status;
              state_nxt        = S_REPLY;
            end else if (!first_r && (sts.rejected || !sts.loading)) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.clear_rejected = first_r;
              cmd.store          = has_r;
              if (has_r && sts.page_end) begin
                // This byte completes a page: write the whole page out.
                cmd.flush_start = 1'b1;
                cmd.flush_full  = 1'b1;
                flush_final_nxt = !lastp_r;
                reply_after_nxt = lastp_r;
                state_nxt       = S_FLUSH_RD;
              end else if (lastp_r) begin
                state_nxt = S_REPLY;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
          MODE_COMMIT: begin
            if (!sts.loading) begin
              status_nxt = ST_NO_COMMIT;
              state_nxt  = S_REPLY;
            end else if (sts.below) begin
              status_nxt = ST_FAULT;
              state_nxt  = S_REPLY;
            end else begin
              cmd.clear_loading = 1'b1;
              if (sts.fill_zero) begin
                state_nxt = S_REPLY;
              end else begin
                // Partial page: write out the buffered bytes first.
                cmd.flush_start = 1'b1;
                flush_final_nxt = 1'b0;
                reply_after_nxt = 1'b1;
                state_nxt       = S_FLUSH_RD;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FLUSH_RD: begin
        state_nxt = S_FLUSH_WR;
      end

      S_FLUSH_WR: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          cmd.byte_last = flush_final_r && sts.flush_done;
          if (sts.flush_done) begin
            state_nxt = reply_after_r ? S_REPLY : S_IDLE;
          end else begin
            cmd.flush_next = 1'b1;
            state_nxt      = S_FLUSH_RD;
          end
        end
      end

      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit_reply = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered controls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mode_r        <= mode_nxt;
    first_r       <= first_nxt;
    lastp_r       <= lastp_nxt;
    has_r         <= has_nxt;
    status_r      <= status_nxt;
    stop_r        <= stop_nxt;
    flush_final_r <= flush_final_nxt;
    reply_after_r <= reply_after_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/fpl_dp.sv @@
// Datapath of the flash page loader: registers, page buffer, flush counter and result register.
`default_nettype none

module fpl_dp
  import fpl_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [ADDR_W-1:0]  cfg_data,
  input  wire  [ADDR_W-1:0]  in_claimed_address,
  input  wire  [BYTE_W-1:0]  in_data_byte,
  input  fpl_cmd_t           cmd,
  output fpl_sts_t           sts,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_kind,
  output logic [2:0]         out_status,
  output logic               out_stage,
  output logic [ADDR_W-1:0]  out_address_out,
  output logic [BYTE_W-1:0]  out_write_byte,
  output logic               out_stop_app,
  output logic               out_last
);

  logic [ADDR_W-1:0]         app_start_r, lowest_r;
  logic                      loading_r, rejected_r;
  logic [ADDR_W-1:0]         wa_r;
  logic [ADDR_W-1:0]         claimed_r;
  logic [BYTE_W-1:0]         data_r;
  logic [ADDR_W-PAGE_AW-1:0] page_r;
  logic [PAGE_AW-1:0]        idx_r, last_idx_r;
  logic [BYTE_W-1:0]         rd_byte;

  logic                      out_valid_r, out_kind_r, out_stage_r, out_stop_r, out_last_r;
  logic [2:0]                out_status_r;
  logic [ADDR_W-1:0]         out_addr_r;
  logic [BYTE_W-1:0]         out_byte_r;

  // Page buffer, indexed by the low bits of the write address.
  fpl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_page_buf (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wa_r[PAGE_AW-1:0]),
    .wdata (data_r),
    .raddr (idx_r),
    .rdata (rd_byte)
  );

  // Status towards the controller.
  always_comb begin
    sts.loading    = loading_r;
    sts.rejected   = rejected_r;
    sts.below      = (wa_r < lowest_r);
    sts.match      = (claimed_r == wa_r);
    sts.page_end   = (wa_r[PAGE_AW-1:0] == PAGE_AW'(PAGE_BYTES - 1));
    sts.fill_zero  = (wa_r[PAGE_AW-1:0] == '0);
    sts.flush_done = (idx_r == last_idx_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Configuration registers and loader control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_start_r <= APP_START_RESET;
      lowest_r    <= LOWEST_RESET;
      loading_r   <= 1'b0;
      rejected_r  <= 1'b0;
      wa_r        <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_APP_START) begin
        app_start_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_LOWEST) begin
        lowest_r <= cfg_data;
      end
      if (cmd.start) begin
        loading_r <= 1'b1;
        wa_r      <= app_start_r;
      end else if (cmd.store) begin
        wa_r <= wa_r + ADDR_W'(1);
      end
      if (cmd.clear_loading) begin
        loading_r <= 1'b0;
      end
      if (cmd.set_rejected) begin
        rejected_r <= 1'b1;
      end else if (cmd.clear_rejected) begin
        rejected_r <= 1'b0;
      end
    end
  end

  // Transaction payload capture and flush counter.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      claimed_r <= in_claimed_address;
      data_r    <= in_data_byte;
    end
    if (cmd.flush_start) begin
      page_r     <= wa_r[ADDR_W-1:PAGE_AW];
      idx_r      <= '0;
      last_idx_r <= cmd.flush_full ? PAGE_AW'(PAGE_BYTES - 1)
                                   : wa_r[PAGE_AW-1:0] - PAGE_AW'(1);
    end else if (cmd.flush_next) begin
      idx_r <= idx_r + PAGE_AW'(1);
    end
  end

  // Result register: holds a transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_reply || cmd.emit_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_reply) begin
      out_kind_r   <= KIND_REPLY;
      out_status_r <= cmd.reply_status;
      out_stage_r  <= loading_r;
      out_addr_r   <= wa_r;
      out_byte_r   <= '0;
      out_stop_r   <= cmd.reply_stop;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_byte) begin
      out_kind_r   <= KIND_WRITE;
      out_status_r <= ST_OK;
      out_stage_r  <= 1'b0;
      out_addr_r   <= {page_r, idx_r};
      out_byte_r   <= rd_byte;
      out_stop_r   <= 1'b0;
      out_last_r   <= cmd.byte_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_stage       = out_stage_r;
  assign out_address_out = out_addr_r;
  assign out_write_byte  = out_byte_r;
  assign out_stop_app    = out_stop_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire
